// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the route table.
// Depends on nothing; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ON(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== sv/rta_pkg.sv =====
// Shared widths, codes and the table entry type of the route table.
// Depends on nothing; used by the channel interfaces and the route table module.
package rta_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int REQ_W      = 2;
  localparam int KEY_W      = 32;
  localparam int MAC_W      = 48;
  localparam int IFC_W      = 4;
  localparam int HOPS_W     = 8;
  localparam int STAMP_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 4;
  localparam int LIMIT_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_KEPT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_STALE     = 3'd7;

  // Configuration register word indexes.
  localparam logic [CFG_ADDR_W-3:0] REG_STALENESS = 1'd0;

  localparam logic [LIMIT_W-1:0] STALENESS_RESET = 16'd5;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [MAC_W-1:0]   next_hop;
    logic [IFC_W-1:0]   iface;
    logic [HOPS_W-1:0]  hops;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/rta_in_if.sv =====
// Request channel of the route table: valid/ready handshake plus request fields.
// Depends on rta_pkg for the field widths.
interface rta_in_if;
  logic                          valid;
  logic                          ready;
  logic [rta_pkg::REQ_W-1:0]     req_type;
  logic [rta_pkg::KEY_W-1:0]     dest_addr;
  logic [rta_pkg::MAC_W-1:0]     next_hop_mac;
  logic [rta_pkg::IFC_W-1:0]     iface_index;
  logic [rta_pkg::HOPS_W-1:0]    hop_count;
  logic                          force_update;

  modport source (
    output valid, req_type, dest_addr, next_hop_mac, iface_index, hop_count, force_update,
    input  ready
  );

  modport sink (
    input  valid, req_type, dest_addr, next_hop_mac, iface_index, hop_count, force_update,
    output ready
  );
endinterface

// ===== sv/rta_out_if.sv =====
// Result channel of the route table: valid/ready handshake plus result fields.
// Depends on rta_pkg for the field widths.
interface rta_out_if;
  logic                          valid;
  logic                          ready;
  logic [rta_pkg::STATUS_W-1:0]  status;
  logic [rta_pkg::SLOT_W-1:0]    slot;
  logic [rta_pkg::MAC_W-1:0]     route_next_hop;
  logic [rta_pkg::IFC_W-1:0]     route_iface;
  logic [rta_pkg::HOPS_W-1:0]    route_hops;

  modport source (
    output valid, status, slot, route_next_hop, route_iface, route_hops,
    input  ready
  );

  modport sink (
    input  valid, status, slot, route_next_hop, route_iface, route_hops,
    output ready
  );
endinterface

// ===== sv/rta_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/route_table_with_aging.sv =====
// Route table with aging: one request beat in, exactly one result beat out.
// A tick or an unknown request goes straight to the response step; an add or a query first
// scans the slots in order until a key matches or all TABLE_DEPTH slots are read, then
// executes; the scan reads one slot per cycle over the entry RAM read port.
// Only one request is in flight; the next is accepted once the last result has been loaded.
// Reset (synchronous, active low) clears the counter and slot marks, loads limit 5; no sweep.
`include "assert_macros.svh"

module route_table_with_aging #(
  parameter int TABLE_DEPTH = rta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rta_in_if.sink                          in_bus,
  rta_out_if.source                       out_bus,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rta_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rta_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rta_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  // -------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so no access is extended by wait states. The word index is the byte
  // address divided by four.
  // -------------------------------------------------------------------------
  logic [rta_pkg::LIMIT_W-1:0]      limit_r;
  logic [rta_pkg::CFG_ADDR_W-3:0]   cfg_idx;
  logic                             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[rta_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == rta_pkg::REG_STALENESS) ?
                   {{(rta_pkg::CFG_DATA_W-rta_pkg::LIMIT_W){1'b0}}, limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rta_pkg::STALENESS_RESET;
    end else if (cfg_wr && (cfg_idx == rta_pkg::REG_STALENESS)) begin
      limit_r <= pwdata[rta_pkg::LIMIT_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // State. The per-slot occupied and live marks are flip-flops so that reset
  // clears them at once; key, next hop, interface, hops and stamp live in one
  // RAM row per slot.
  // -------------------------------------------------------------------------
  logic [1:0]                     state_r, state_nxt;
  logic [rta_pkg::STAMP_W-1:0]    now_r, now_nxt;
  logic [TABLE_DEPTH-1:0]         used_r, used_nxt;
  logic [TABLE_DEPTH-1:0]         live_r, live_nxt;

  // Request captured at acceptance.
  logic [rta_pkg::REQ_W-1:0]      req_r;
  logic [rta_pkg::KEY_W-1:0]      key_r;
  logic [rta_pkg::MAC_W-1:0]      mac_r;
  logic [rta_pkg::IFC_W-1:0]      ifc_r;
  logic [rta_pkg::HOPS_W-1:0]     hops_r;
  logic                           force_r;

  // Scan bookkeeping. A read issued in one cycle is checked in the next.
  logic [CNT_W-1:0]               iss_cnt_r, iss_cnt_nxt;
  logic                           chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]               chk_idx_r, chk_idx_nxt;
  logic                           hit_r, hit_nxt;
  logic [IDX_W-1:0]               hit_idx_r, hit_idx_nxt;
  logic                           emp_vld_r, emp_vld_nxt;
  logic [IDX_W-1:0]               emp_idx_r, emp_idx_nxt;

  // Result waiting to move into the output register.
  logic [rta_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [rta_pkg::SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic [rta_pkg::MAC_W-1:0]      res_mac_r, res_mac_nxt;
  logic [rta_pkg::IFC_W-1:0]      res_ifc_r, res_ifc_nxt;
  logic [rta_pkg::HOPS_W-1:0]     res_hops_r, res_hops_nxt;

  // Output register.
  logic                           out_vld_r, out_vld_nxt;
  logic [rta_pkg::STATUS_W-1:0]   out_status_r;
  logic [rta_pkg::SLOT_W-1:0]     out_slot_r;
  logic [rta_pkg::MAC_W-1:0]      out_mac_r;
  logic [rta_pkg::IFC_W-1:0]      out_ifc_r;
  logic [rta_pkg::HOPS_W-1:0]     out_hops_r;
  logic                           out_load;

  // Entry RAM ports.
  logic                           ram_we, ram_re;
  logic [IDX_W-1:0]               ram_waddr, ram_raddr;
  rta_pkg::entry_t                wr_ent, rd_ent;
  logic [rta_pkg::ENTRY_W-1:0]    ram_rdata;

  rta_ram #(
    .WIDTH (rta_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = rta_pkg::entry_t'(ram_rdata);

  // -------------------------------------------------------------------------
  // Scan datapath. The lowest occupied slot whose key matches wins; the read
  // stream stops on a hit so the RAM output keeps the hit row for the
  // execute cycle. The first empty slot is noted as the reads go out.
  // -------------------------------------------------------------------------
  logic hit_now;
  logic issue;

  assign hit_now   = chk_vld_r && used_r[chk_idx_r] && (rd_ent.key == key_r);
  assign issue     = (iss_cnt_r != CNT_END) && !hit_now;
  assign ram_raddr = iss_cnt_r[IDX_W-1:0];
  assign ram_re    = (state_r == ST_SCAN) && issue;

  // Slot numbers on the result channel are the index taken modulo 16.
  logic [IDX_W+rta_pkg::SLOT_W-1:0] hit_ext, emp_ext;
  assign hit_ext = {{rta_pkg::SLOT_W{1'b0}}, hit_idx_r};
  assign emp_ext = {{rta_pkg::SLOT_W{1'b0}}, emp_idx_r};

  // Age is the modular difference between the clock and the stamp.
  logic [rta_pkg::STAMP_W-1:0] age;
  logic                        fresh;
  assign age   = now_r - rd_ent.stamp;
  assign fresh = age < {{(rta_pkg::STAMP_W-rta_pkg::LIMIT_W){1'b0}}, limit_r};

  assign in_bus.ready = (state_r == ST_IDLE);
  assign out_load     = !out_vld_r || out_bus.ready;

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    used_nxt       = used_r;
    live_nxt       = live_r;
    iss_cnt_nxt    = iss_cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    emp_vld_nxt    = emp_vld_r;
    emp_idx_nxt    = emp_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_mac_nxt    = res_mac_r;
    res_ifc_nxt    = res_ifc_r;
    res_hops_nxt   = res_hops_r;
    out_vld_nxt    = out_vld_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    wr_ent.key      = key_r;
    wr_ent.next_hop = mac_r;
    wr_ent.iface    = ifc_r;
    wr_ent.hops     = hops_r;
    wr_ent.stamp    = now_r;

    // The output register drains independently of the controller.
    if (out_vld_r && out_bus.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        iss_cnt_nxt = '0;
        chk_vld_nxt = 1'b0;
        hit_nxt     = 1'b0;
        emp_vld_nxt = 1'b0;
        res_status_nxt = rta_pkg::ST_TICK_DONE;
        res_slot_nxt   = '0;
        res_mac_nxt    = '0;
        res_ifc_nxt    = '0;
        res_hops_nxt   = '0;
        if (in_bus.valid) begin
          case (in_bus.req_type)
            rta_pkg::REQ_TICK: begin
              now_nxt   = now_r + 1'b1;
              state_nxt = ST_RESP;
            end
            rta_pkg::REQ_ADD,
            rta_pkg::REQ_QUERY: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              // Unknown request: no state change, an all-zero result.
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        chk_vld_nxt = issue;
        chk_idx_nxt = ram_raddr;
        if (issue) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          if (!used_r[ram_raddr] && !emp_vld_r) begin
            emp_vld_nxt = 1'b1;
            emp_idx_nxt = ram_raddr;
          end
        end
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = chk_idx_r;
          state_nxt   = ST_EXEC;
        end else if (!chk_vld_r && (iss_cnt_r == CNT_END)) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_RESP;
        if (req_r == rta_pkg::REQ_ADD) begin
          if (hit_r) begin
            res_slot_nxt = hit_ext[rta_pkg::SLOT_W-1:0];
            // A dead entry still competes with its stored hop count.
            if (force_r || (rd_ent.hops > hops_r)) begin
              ram_we              = 1'b1;
              live_nxt[hit_idx_r] = 1'b1;
              res_status_nxt      = rta_pkg::ST_UPDATED;
            end else begin
              res_status_nxt = rta_pkg::ST_KEPT;
            end
          end else if (emp_vld_r) begin
            ram_we              = 1'b1;
            ram_waddr           = emp_idx_r;
            used_nxt[emp_idx_r] = 1'b1;
            live_nxt[emp_idx_r] = 1'b1;
            res_status_nxt      = rta_pkg::ST_INSERTED;
            res_slot_nxt        = emp_ext[rta_pkg::SLOT_W-1:0];
          end else begin
            res_status_nxt = rta_pkg::ST_FULL;
          end
        end else begin
          if (!hit_r || !live_r[hit_idx_r]) begin
            res_status_nxt = rta_pkg::ST_NO_ROUTE;
          end else if (fresh) begin
            res_status_nxt = rta_pkg::ST_FRESH;
            res_slot_nxt   = hit_ext[rta_pkg::SLOT_W-1:0];
            res_mac_nxt    = rd_ent.next_hop;
            res_ifc_nxt    = rd_ent.iface;
            res_hops_nxt   = rd_ent.hops;
          end else begin
            live_nxt[hit_idx_r] = 1'b0;
            res_status_nxt      = rta_pkg::ST_STALE;
            res_slot_nxt        = hit_ext[rta_pkg::SLOT_W-1:0];
          end
        end
      end

      ST_RESP: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      now_r     <= '0;
      used_r    <= '0;
      live_r    <= '0;
      iss_cnt_r <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      emp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      used_r    <= used_nxt;
      live_r    <= live_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      hit_r     <= hit_nxt;
      emp_vld_r <= emp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    emp_idx_r    <= emp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_mac_r    <= res_mac_nxt;
    res_ifc_r    <= res_ifc_nxt;
    res_hops_r   <= res_hops_nxt;
    if (in_bus.valid && in_bus.ready) begin
      req_r   <= in_bus.req_type;
      key_r   <= in_bus.dest_addr;
      mac_r   <= in_bus.next_hop_mac;
      ifc_r   <= in_bus.iface_index;
      hops_r  <= in_bus.hop_count;
      force_r <= in_bus.force_update;
    end
    if ((state_r == ST_RESP) && out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_mac_r    <= res_mac_r;
      out_ifc_r    <= res_ifc_r;
      out_hops_r   <= res_hops_r;
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.slot           = out_slot_r;
  assign out_bus.route_next_hop = out_mac_r;
  assign out_bus.route_iface    = out_ifc_r;
  assign out_bus.route_hops     = out_hops_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  // A slot can only be live while it is occupied.
  `ASSERT_NEVER(a_live_without_used, clk, rst_n, (live_r & ~used_r) != '0)
  // Every row written to the RAM belongs to an occupied slot afterwards.
  `ASSERT_ON(a_write_marks_used, clk, rst_n, ram_we |=> used_r[$past(ram_waddr)])
  // A result beat only appears after the controller passed through its response step.
  `ASSERT_ON(a_out_from_resp, clk, rst_n, $rose(out_vld_r) |-> $past(state_r) == ST_RESP)

endmodule
